// ===== hw/rtl/patch_unfold_pixel_normalizer_top_assert.svh =====
// Assertion macros shared by the normalizer RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef PATCH_UNFOLD_PIXEL_NORMALIZER_TOP_ASSERT_SVH
`define PATCH_UNFOLD_PIXEL_NORMALIZER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`define PFN_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
`else
`define PFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define PFN_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/pfn_pkg.sv =====
// Shared constants, register codes and the fp16 normalization table.
// No dependencies.
package pfn_pkg;

    localparam int PFN_PATCH    = 14;
    localparam int PFN_MAX_SIDE = 1022;
    localparam int PFN_SIDE_W   = 10;
    localparam int PFN_IDX_W    = 20;
    localparam int PFN_HALF_W   = 16;
    localparam int PFN_ADDR_W   = 3;
    localparam int PFN_DATA_W   = 32;
    localparam int NormDen      = 255;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [PFN_HALF_W-1:0] t_half_lut [0:255];

    // (v/255 - 0.5)/0.5 = (2v-255)/255, rounded once to fp16; the binary
    // expansion repeats every 8 bits, so no tie arises and a single rounding
    // matches the double-then-float-then-half path.
    function automatic t_half_lut build_norm_lut();
        t_half_lut lut;
        int        n;
        int        k;
        int        num;
        int        q;
        int        r;
        int        e;
        logic      sgn;
        for (int v = 0; v < 256; v++) begin
            n   = 2 * v - NormDen;
            sgn = (n < 0);
            if (n < 0) begin
                n = -n;
            end
            k = 0;
            for (int j = 0; j < 8; j++) begin
                if ((n << k) < NormDen) begin
                    k++;
                end
            end
            num = n << (k + 10);
            q   = num / NormDen;
            r   = num - q * NormDen;
            if (2 * r > NormDen) begin
                q++;
            end
            e = 15 - k;
            if (q >= 2048) begin
                q = 1024;
                e++;
            end
            lut[v] = {sgn, 5'(e), 10'(q - 1024)};
        end
        return lut;
    endfunction

    localparam t_half_lut NORM_LUT = build_norm_lut();

endpackage

// ===== hw/rtl/pfn_div.sv =====
// Divide by a constant through a reciprocal multiply, with remainder.
// Depends on nothing; used by the top level for row and size splits.
module pfn_div #(
    parameter int Divisor = 14,
    parameter int InW     = 10,
    parameter int RemW    = 4
) (
    input  logic [InW-1:0]  i_x,
    output logic [InW-1:0]  o_quo,
    output logic [RemW-1:0] o_rem
);
    localparam int DivShift = InW + $clog2(Divisor);
    localparam int MulW     = DivShift + 1;
    localparam int DivMul   = ((1 << DivShift) + Divisor - 1) / Divisor;

    logic [InW+MulW-1:0] w_prod;
    logic [InW-1:0]      w_back;

    assign w_prod = (InW+MulW)'(i_x) * (InW+MulW)'(DivMul);
    assign o_quo  = InW'(w_prod >> DivShift);
    assign w_back = InW'(o_quo * InW'(Divisor));
    assign o_rem  = RemW'(i_x - w_back);
endmodule

// ===== hw/rtl/patch_unfold_pixel_normalizer_top.sv =====
// Patch-unfold pixel normalizer: o_valid marks each accepted start once it has
// passed the register stages below; one pixel accepted every cycle, busy never rises.
// Four register stages: constant divides and table lookup, two multiply
// stages, final multiply-add. The receiver cannot stall the pipe.
// Synchronous active-low reset clears valid bits and sets the sizes to 448.
`include "patch_unfold_pixel_normalizer_top_assert.svh"
module patch_unfold_pixel_normalizer_top
    import pfn_pkg::*;
#(
    parameter int PATCH    = PFN_PATCH,
    parameter int MAX_SIDE = PFN_MAX_SIDE
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [PFN_SIDE_W-1:0]  i_column,
    input  logic [PFN_SIDE_W-1:0]  i_row,
    input  logic [7:0]             i_red,
    input  logic [7:0]             i_green,
    input  logic [7:0]             i_blue,
    output logic                   o_valid,
    output logic [PFN_IDX_W-1:0]   o_dest_index,
    output logic [PFN_HALF_W-1:0]  o_red_half,
    output logic [PFN_HALF_W-1:0]  o_green_half,
    output logic [PFN_HALF_W-1:0]  o_blue_half,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PFN_ADDR_W-1:0]  paddr,
    input  logic [PFN_DATA_W-1:0]  pwdata,
    output logic [PFN_DATA_W-1:0]  prdata,
    output logic                   pready
);
    localparam int RemW = (PATCH > 1) ? $clog2(PATCH) : 1;
    localparam logic [PFN_IDX_W-1:0] PatchIdx = PFN_IDX_W'(PATCH);

    logic [PFN_SIDE_W-1:0] r_image_width, r_image_height;
    logic                  w_cfg_wr;
    t_reg_idx              w_cfg_idx;
    logic [PFN_SIDE_W-1:0] w_cfg_value;
    logic                  w_accept;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign w_accept  = start && !busy;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg_idx'(paddr[2]);

    // Saturate oversized sizes.
    always_comb begin
        w_cfg_value = pwdata[PFN_SIDE_W-1:0];
        if (32'(pwdata[PFN_SIDE_W-1:0]) > 32'(MAX_SIDE)) begin
            w_cfg_value = PFN_SIDE_W'(MAX_SIDE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= PFN_SIDE_W'(448);
            r_image_height <= PFN_SIDE_W'(448);
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= w_cfg_value;
                REG_IMAGE_HEIGHT: r_image_height <= w_cfg_value;
                default:          r_image_width  <= r_image_width;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_IMAGE_WIDTH:  prdata = PFN_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = PFN_DATA_W'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    // Stage 1: split row, derive patch counts, look up halves.
    logic [PFN_SIDE_W-1:0] w_rq, w_pw, w_ph;
    logic [RemW-1:0]       w_rr, w_pw_rem, w_ph_rem;

    pfn_div #(.Divisor(PATCH), .InW(PFN_SIDE_W), .RemW(RemW)) u_div_row (
        .i_x(i_row), .o_quo(w_rq), .o_rem(w_rr));
    pfn_div #(.Divisor(PATCH), .InW(PFN_SIDE_W), .RemW(RemW)) u_div_w (
        .i_x(r_image_width), .o_quo(w_pw), .o_rem(w_pw_rem));
    pfn_div #(.Divisor(PATCH), .InW(PFN_SIDE_W), .RemW(RemW)) u_div_h (
        .i_x(r_image_height), .o_quo(w_ph), .o_rem(w_ph_rem));

    logic [3:0]            r_vld;
    logic [PFN_SIDE_W-1:0] r1_rq, r1_pw, r1_ph, r1_col, r2_ph, r2_col;
    logic [RemW-1:0]       r1_rr;
    logic [PFN_IDX_W-1:0]  r2_a, r2_b, r3_a, r3_b, r3_col;
    logic [PFN_HALF_W-1:0] r1_hr, r1_hg, r1_hb, r2_hr, r2_hg, r2_hb;
    logic [PFN_HALF_W-1:0] r3_hr, r3_hg, r3_hb;
    logic [3:0]            n_vld;

    assign n_vld = {r_vld[2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_rq  <= w_rq;
        r1_rr  <= w_rr;
        r1_pw  <= w_pw;
        r1_ph  <= w_ph;
        r1_col <= i_column;
        r1_hr  <= NORM_LUT[i_red];
        r1_hg  <= NORM_LUT[i_green];
        r1_hb  <= NORM_LUT[i_blue];

        r2_a   <= PFN_IDX_W'(r1_rr) * PFN_IDX_W'(r1_pw);
        r2_b   <= PFN_IDX_W'(r1_rq) * PFN_IDX_W'(r1_pw);
        r2_ph  <= r1_ph;
        r2_col <= r1_col;
        r2_hr  <= r1_hr;
        r2_hg  <= r1_hg;
        r2_hb  <= r1_hb;

        r3_a   <= r2_a * PFN_IDX_W'(r2_ph);
        r3_b   <= r2_b * PatchIdx;
        r3_col <= PFN_IDX_W'(r2_col);
        r3_hr  <= r2_hr;
        r3_hg  <= r2_hg;
        r3_hb  <= r2_hb;

        // patch*P + column%P collapses to (row/P)*PW*P + column.
        o_dest_index <= r3_a * PatchIdx + r3_b + r3_col;
        o_red_half   <= r3_hr;
        o_green_half <= r3_hg;
        o_blue_half  <= r3_hb;
    end

    assign o_valid = r_vld[3];

    `PFN_ASSERT_NEXT(a_cfg_width, i_clk, i_rst_n, w_cfg_wr && w_cfg_idx == REG_IMAGE_WIDTH, r_image_width == $past(w_cfg_value))
    `PFN_ASSERT_NEXT(a_cfg_height, i_clk, i_rst_n, w_cfg_wr && w_cfg_idx == REG_IMAGE_HEIGHT, r_image_height == $past(w_cfg_value))
    `PFN_ASSERT_NOW(a_strobe_origin, i_clk, i_rst_n, o_valid && $past(i_rst_n, 4), $past(w_accept, 4))
    `PFN_ASSERT_NOW(a_pipe_tracks, i_clk, i_rst_n, r_vld[1], $past(r_vld[0]))
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for patch_unfold_pixel_normalizer_top: drives pixel beats and
// APB size writes, predicts unfolded index and fp16 samples. Depends on pfn_pkg and the RTL.
`timescale 1ns / 100ps
module tb_top;
    import pfn_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [PFN_IDX_W-1:0]  dest_index;
        logic [PFN_HALF_W-1:0] red_half;
        logic [PFN_HALF_W-1:0] green_half;
        logic [PFN_HALF_W-1:0] blue_half;
    } t_pixel_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [PFN_SIDE_W-1:0] i_column = '0;
    logic [PFN_SIDE_W-1:0] i_row = '0;
    logic [7:0]            i_red = '0;
    logic [7:0]            i_green = '0;
    logic [7:0]            i_blue = '0;
    logic                  o_valid;
    logic [PFN_IDX_W-1:0]  o_dest_index;
    logic [PFN_HALF_W-1:0] o_red_half;
    logic [PFN_HALF_W-1:0] o_green_half;
    logic [PFN_HALF_W-1:0] o_blue_half;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PFN_ADDR_W-1:0] paddr = '0;
    logic [PFN_DATA_W-1:0] pwdata = '0;
    logic [PFN_DATA_W-1:0] prdata;
    logic                  pready;

    t_pixel_out pending_pixels[$];
    int         mismatch_count = 0;
    int         pixel_count = 0;
    int         result_count = 0;
    int         size_writes = 0;
    int         cycle_count = 0;
    int         sender_idle_pct = 0;
    int         cfg_width = 448;
    int         cfg_height = 448;

    patch_unfold_pixel_normalizer_top dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Round the double to fp32 (nearest even), then fp32 to fp16.
    function automatic logic [15:0] half_of_sample(logic [7:0] v);
        real          d;
        logic [63:0]  db;
        logic [30:0]  mag;
        logic [28:0]  dropped;
        logic [31:0]  w;
        logic [15:0]  sgn;
        int           e;
        int           he;
        int           sh;
        logic [23:0]  m;
        logic [23:0]  val;
        logic [23:0]  rem;
        logic [23:0]  halfway;
        d = (real'(v) / 255.0 - 0.5) / 0.5;
        db = $realtobits(d);
        if (db[62:0] == '0) begin
            w = {db[63], 31'd0};
        end else begin
            mag = {8'(int'(db[62:52]) - 1023 + 127), db[51:29]};
            dropped = db[28:0];
            if (dropped > 29'h1000_0000 || (dropped == 29'h1000_0000 && mag[0]))
                mag = mag + 1;
            w = {db[63], mag};
        end
        sgn = {w[31], 15'd0};
        e = int'(w[30:23]);
        m = {1'b0, w[22:0]};
        if (e == 255) return sgn | (m != 0 ? 16'h7E00 : 16'h7C00);
        if (e == 0) return sgn;
        he = e - 112;
        if (he >= 31) return sgn | 16'h7C00;
        if (he >= 1) begin
            val = (24'(he) << 10) | (m >> 13);
            rem = m & 24'h1FFF;
            if (rem > 24'h1000 || (rem == 24'h1000 && val[0])) val = val + 1;
            return sgn | val[15:0];
        end
        sh = 14 - he;
        if (sh > 24) return sgn;
        m = m | 24'h80_0000;
        val = m >> sh;
        rem = m & ((24'd1 << sh) - 1);
        halfway = 24'd1 << (sh - 1);
        if (rem > halfway || (rem == halfway && val[0])) val = val + 1;
        return sgn | val[15:0];
    endfunction

    function automatic t_pixel_out unfold_and_normalize(logic [9:0] col, logic [9:0] row,
                                                       logic [7:0] r, logic [7:0] g,
                                                       logic [7:0] b);
        t_pixel_out       p;
        longint unsigned  pw;
        longint unsigned  ph;
        longint unsigned  patch_no;
        longint unsigned  idx;
        pw = cfg_width / PFN_PATCH;
        ph = cfg_height / PFN_PATCH;
        patch_no = (row / PFN_PATCH) * pw + col / PFN_PATCH;
        idx = (row % PFN_PATCH) * pw * ph * PFN_PATCH + patch_no * PFN_PATCH
            + col % PFN_PATCH;
        p.dest_index = idx[PFN_IDX_W-1:0];
        p.red_half = half_of_sample(r);
        p.green_half = half_of_sample(g);
        p.blue_half = half_of_sample(b);
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("mismatch %s: got 0x%0h expected 0x%0h (cycle %0d)", what, got, want,
                 cycle_count);
    endtask

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected result", o_dest_index, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_dest_index !== want.dest_index)
                    report_mismatch("dest_index", o_dest_index, want.dest_index);
                if (o_red_half !== want.red_half)
                    report_mismatch("red_half", o_red_half, want.red_half);
                if (o_green_half !== want.green_half)
                    report_mismatch("green_half", o_green_half, want.green_half);
                if (o_blue_half !== want.blue_half)
                    report_mismatch("blue_half", o_blue_half, want.blue_half);
            end
        end
    end

    // Drive one pixel beat and hold it until accepted; idle gaps follow at random.
    task automatic send_pixel(logic [9:0] col, logic [9:0] row, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b);
        start <= 1'b1;
        i_column <= col;
        i_row <= row;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_pixels.insert(pending_pixels.size(), unfold_and_normalize(col, row, r, g, b));
        pixel_count++;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(t_reg_idx which, logic [31:0] value);
        int v;
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PFN_ADDR_W'(int'(which) * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        v = int'(value[9:0]);
        if (v > PFN_MAX_SIDE) v = PFN_MAX_SIDE;
        if (which == REG_IMAGE_WIDTH) cfg_width = v;
        else cfg_height = v;
        size_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(logic [31:0] w, logic [31:0] h);
        write_size(REG_IMAGE_WIDTH, w);
        write_size(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic test_directed();
        sender_idle_pct = 0;
        send_pixel(10'd0, 10'd0, 8'd0, 8'd255, 8'd127);
        send_pixel(10'd447, 10'd447, 8'd128, 8'd1, 8'd254);
        send_pixel(10'd13, 10'd14, 8'd255, 8'd0, 8'd128);
        send_pixel(10'd1021, 10'd1021, 8'd85, 8'd170, 8'd51);
        send_pixel(10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255);
        // pixel outside the image
        set_sizes(32'd1022, 32'd1022);
        send_pixel(10'd1023, 10'd1023, 8'd0, 8'd0, 8'd0);
        send_pixel(10'd1021, 10'd13, 8'd64, 8'd192, 8'd32);
        // writes above the largest side saturate, high data bits ignored
        set_sizes(32'hFFFF_FFFF, 32'd1023);
        send_pixel(10'd1000, 10'd1000, 8'd200, 8'd100, 8'd10);
        // sizes that are not multiples of the patch
        set_sizes(32'd100, 32'd50);
        send_pixel(10'd99, 10'd49, 8'd3, 8'd250, 8'd127);
        send_pixel(10'd98, 10'd42, 8'd126, 8'd129, 8'd2);
        // sizes below the patch give zero patches per side
        set_sizes(32'd5, 32'd0);
        send_pixel(10'd4, 10'd3, 8'd17, 8'd34, 8'd68);
        send_pixel(10'd700, 10'd900, 8'd240, 8'd15, 8'd99);
        set_sizes(32'd14, 32'd14);
        send_pixel(10'd13, 10'd13, 8'd0, 8'd255, 8'd0);
        send_pixel(10'd14, 10'd0, 8'd255, 8'd0, 8'd255);
    endtask

    task automatic test_random_phase(logic [31:0] w, logic [31:0] h, int idle_pct, int items);
        int          lim_c;
        int          lim_r;
        logic [9:0]  col;
        logic [9:0]  row;
        set_sizes(w, h);
        sender_idle_pct = idle_pct;
        lim_c = (cfg_width > 0) ? cfg_width - 1 : 0;
        lim_r = (cfg_height > 0) ? cfg_height - 1 : 0;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(9) < 8) begin
                col = 10'($urandom_range(lim_c));
                row = 10'($urandom_range(lim_r));
            end else begin
                col = 10'($urandom);
                row = 10'($urandom);
            end
            send_pixel(col, row, 8'($urandom), 8'($urandom), 8'($urandom));
            // halfway through a phase with idle gaps, hold off until the pipe has emptied
            if (n == items / 2 && idle_pct > 0) begin
                start <= 1'b0;
                while (pending_pixels.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(32'd448, 32'd448, 0, 120);
        test_random_phase(32'd1022, 32'd1022, 52, 120);
        test_random_phase(32'd14, 32'd980, 0, 100);
        test_random_phase(32'd980, 32'd28, 8, 120);
        test_random_phase(32'd210, 32'd1023, 52, 120);
        test_random_phase(32'd30, 32'd7, 8, 120);
        wait_drained();
        $display("run covered %0d pixels, %0d results, %0d size writes", pixel_count,
                 result_count, size_writes);
        $display("sizes from below the patch to saturation, idle phases 0/8/52 percent");
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
